[src/issc_pkg.sv]
// Package for the isotropic stress/strain converter.
// Shared widths, codes and divider pipeline depth; no dependencies.
`default_nettype none
package issc_pkg;

  // Fixed-point one in Q16.16 / Q0.16
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Divider lane widths: numerator magnitude, divisor, quotient
  localparam int NUM_W = 81;
  localparam int DEN_W = 33;
  localparam int QUO_W = 32;

  // Divider lane depth: prepare stage, one stage per quotient bit, output
  localparam int DIV_LAT = QUO_W + 2;

  // Operation codes carried in tuser
  localparam logic OP_STRAIN = 1'b0;  // strain from stress
  localparam logic OP_STRESS = 1'b1;  // stress from strain

  // Register indexes
  localparam logic REG_YOUNGS  = 1'b0;
  localparam logic REG_POISSON = 1'b1;

endpackage
`default_nettype wire

[src/issc_div_lane.sv]
// Pipelined rounding divider lane with signed saturation to 32 bits.
// Uses issc_pkg for widths and depth.
`default_nettype none
module issc_div_lane (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [issc_pkg::NUM_W-1:0]  num_i,  // numerator magnitude
  input  wire logic [issc_pkg::DEN_W-1:0]  den_i,  // divisor
  input  wire logic                        neg_i,  // result sign
  output logic [31:0]                      res_o,
  output logic                             sat_o
);

  localparam int NW = issc_pkg::NUM_W;
  localparam int DW = issc_pkg::DEN_W;
  localparam int QW = issc_pkg::QUO_W;

  // Per-stage state: partial remainder, dividend/quotient word, divisor, flags
  logic [DW-1:0] r_q   [QW+1];
  logic [QW-1:0] w_q   [QW+1];
  logic [DW-1:0] d_q   [QW+1];
  logic          neg_q [QW+1];
  logic          big_q [QW+1];
  logic          dz_q  [QW+1];

  logic [31:0]   res_q;
  logic          sat_q;

  // Prepare: overflow check and initial remainder
  logic          dz_d, big_d;
  always_comb begin
    dz_d  = (den_i == '0);
    big_d = dz_d ? (num_i != '0)
                 : (num_i[NW-1:QW] >= (NW-QW)'(den_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= num_i[QW+DW-1:QW];
      w_q[0]   <= num_i[QW-1:0];
      d_q[0]   <= den_i;
      neg_q[0] <= neg_i;
      big_q[0] <= big_d;
      dz_q[0]  <= dz_d;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] rr;
    logic        ge;
    always_comb begin
      rr = {r_q[k], w_q[k][QW-1]};
      ge = (rr >= {1'b0, d_q[k]});
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge ? DW'(rr - {1'b0, d_q[k]}) : DW'(rr);
        w_q[k+1]   <= {w_q[k][QW-2:0], ge};
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        big_q[k+1] <= big_q[k];
        dz_q[k+1]  <= dz_q[k];
      end
    end
  end

  // Round half away from zero, apply sign, clip
  logic        up;
  logic [QW:0] qr;
  logic        sat_d;
  logic [31:0] res_d;
  always_comb begin
    up    = ({r_q[QW], 1'b0} >= {1'b0, d_q[QW]});
    qr    = dz_q[QW] ? '0 : ({1'b0, w_q[QW]} + (QW+1)'(up));
    if (neg_q[QW]) begin
      sat_d = big_q[QW] || (qr > (QW+1)'(33'h0_8000_0000));
      res_d = sat_d ? 32'h8000_0000 : 32'(-qr);
    end else begin
      sat_d = big_q[QW] || (qr > (QW+1)'(33'h0_7FFF_FFFF));
      res_d = sat_d ? 32'h7FFF_FFFF : qr[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire

[src/isotropic_stress_strain_convert.sv]
// Top level: isotropic Hooke's law, stress <-> strain, Q16.16 fixed point.
// Depends on issc_pkg and issc_div_lane.
//
//  channel   dir  beat contents
//  s_axis    in   tuser: op; tdata: xx yy zz xy xz yz (32b each)
//  m_axis    out  tuser: saturated; tdata: xx yy zz xy xz yz (32b each)
//  apb       in   reg 0 youngs_modulus @0x0, reg 1 poisson_ratio @0x4
//
// One beat per cycle while the output is not stalled; 5 front stages + 34 divider
// stages, set by the bit-per-stage divider (32 quotient bits) in each of six lanes.
// The whole pipeline advances when the output register is empty or taken;
// a stall holds every stage. Reset clears valid bits and loads the config
// registers with their defaults.
`default_nettype none
module isotropic_stress_strain_convert (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [191:0] s_axis_tdata,   // in_xx, in_yy, in_zz, in_xy, in_xz, in_yz
  input  wire logic [0:0]   s_axis_tuser,   // op
  // output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [191:0]      m_axis_tdata,   // out_xx, out_yy, out_zz, out_xy, out_xz, out_yz
  output logic [0:0]        m_axis_tuser,   // saturated
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NW  = issc_pkg::NUM_W;
  localparam int DW  = issc_pkg::DEN_W;
  localparam int LAT = issc_pkg::DIV_LAT;

  // Configuration registers and derived constants
  logic [30:0] e_q;
  logic [14:0] v_q;
  logic [16:0] onev_q;   // 1 + v
  logic [32:0] den_q;    // (1 + v)(1 - 2v)

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= 31'd65536;
      v_q <= 15'd19661;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        issc_pkg::REG_YOUNGS:  e_q <= pwdata[30:0];
        issc_pkg::REG_POISSON: v_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    onev_q <= issc_pkg::ONE_Q16 + 17'(v_q);
    den_q  <= 33'(issc_pkg::ONE_Q16 + 17'(v_q))
            * 33'(issc_pkg::ONE_Q16 - {1'b0, v_q, 1'b0});
  end

  always_comb begin
    case (paddr[2])
      issc_pkg::REG_YOUNGS:  prdata = {1'b0, e_q};
      issc_pkg::REG_POISSON: prdata = {17'b0, v_q};
      default:               prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Pipeline advance
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Valid bits: front stages A..E, then divider lanes
  logic [4:0]     vf_q;
  logic [LAT-1:0] vl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
      vl_q <= '0;
    end else if (en) begin
      vf_q <= {vf_q[3:0], s_axis_tvalid};
      vl_q <= {vl_q[LAT-2:0], vf_q[4]};
    end
  end

  // Stage A: scale normal terms, form cross sums
  logic signed [31:0] t [6];
  logic [16:0]        a_coef;
  always_comb begin
    for (int i = 0; i < 6; i++) t[i] = $signed(s_axis_tdata[32*i +: 32]);
    a_coef = issc_pkg::ONE_Q16 - 17'(v_q);
  end

  logic               op_a_q;
  logic signed [49:0] p_a_q [3];
  logic signed [32:0] s_a_q [3];
  logic signed [31:0] t_a_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      op_a_q <= s_axis_tuser[0];
      for (int i = 0; i < 3; i++) begin
        p_a_q[i] <= (s_axis_tuser[0] == issc_pkg::OP_STRESS)
                  ? 50'(t[i]) * $signed({33'b0, a_coef})
                  : 50'(t[i]) <<< 16;
        t_a_q[i] <= t[i+3];
      end
      s_a_q[0] <= 33'(t[1]) + 33'(t[2]);
      s_a_q[1] <= 33'(t[0]) + 33'(t[2]);
      s_a_q[2] <= 33'(t[0]) + 33'(t[1]);
    end
  end

  // Stage B: v times cross sums, shear numerator product
  logic               op_b_q;
  logic signed [49:0] p_b_q [3];
  logic signed [49:0] q_b_q [3];
  logic signed [63:0] m_b_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      op_b_q <= op_a_q;
      for (int i = 0; i < 3; i++) begin
        p_b_q[i] <= p_a_q[i];
        q_b_q[i] <= 50'(s_a_q[i]) * $signed({35'b0, v_q});
        m_b_q[i] <= 64'(t_a_q[i]) * ((op_a_q == issc_pkg::OP_STRESS)
                  ? $signed({33'b0, e_q}) : $signed({47'b0, onev_q}));
      end
    end
  end

  // Stage C: combine normal terms, split into sign and magnitude
  logic               op_c_q;
  logic [49:0]        nm_c_q [3];
  logic               nn_c_q [3];
  logic [62:0]        sm_c_q [3];
  logic               sn_c_q [3];
  logic signed [50:0] nsum [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      nsum[i] = (op_b_q == issc_pkg::OP_STRESS) ? 51'(p_b_q[i]) + 51'(q_b_q[i])
                                                : 51'(p_b_q[i]) - 51'(q_b_q[i]);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op_c_q <= op_b_q;
      for (int i = 0; i < 3; i++) begin
        nn_c_q[i] <= nsum[i][50];
        nm_c_q[i] <= nsum[i][50] ? 50'(-nsum[i]) : nsum[i][49:0];
        sn_c_q[i] <= m_b_q[i][63];
        sm_c_q[i] <= m_b_q[i][63] ? 63'(-m_b_q[i]) : m_b_q[i][62:0];
      end
    end
  end

  // Stage D: partial products of normal magnitude times E
  logic        op_d_q;
  logic [49:0] nm_d_q [3];
  logic [62:0] lo_d_q [3];
  logic [48:0] hi_d_q [3];
  logic        nn_d_q [3];
  logic [62:0] sm_d_q [3];
  logic        sn_d_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      op_d_q <= op_c_q;
      for (int i = 0; i < 3; i++) begin
        nm_d_q[i] <= nm_c_q[i];
        lo_d_q[i] <= 63'(nm_c_q[i][31:0]) * 63'(e_q);
        hi_d_q[i] <= 49'(nm_c_q[i][49:32]) * 49'(e_q);
        nn_d_q[i] <= nn_c_q[i];
        sm_d_q[i] <= sm_c_q[i];
        sn_d_q[i] <= sn_c_q[i];
      end
    end
  end

  // Stage E: lane numerators and divisors
  logic [NW-1:0] num_e_q [6];
  logic [DW-1:0] den_e_q [6];
  logic          neg_e_q [6];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (op_d_q == issc_pkg::OP_STRESS) begin
          num_e_q[i]   <= (NW'(hi_d_q[i]) << 32) + NW'(lo_d_q[i]);
          den_e_q[i]   <= den_q;
          den_e_q[i+3] <= DW'(onev_q);
        end else begin
          num_e_q[i]   <= NW'(nm_d_q[i]);
          den_e_q[i]   <= DW'(e_q);
          den_e_q[i+3] <= DW'(e_q);
        end
        neg_e_q[i]   <= nn_d_q[i];
        num_e_q[i+3] <= NW'(sm_d_q[i]);
        neg_e_q[i+3] <= sn_d_q[i];
      end
    end
  end

  // Divider lanes
  logic [5:0] sat;
  for (genvar g = 0; g < 6; g++) begin : g_lane
    issc_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_e_q[g]),
      .den_i (den_e_q[g]),
      .neg_i (neg_e_q[g]),
      .res_o (m_axis_tdata[32*g +: 32]),
      .sat_o (sat[g])
    );
  end

  assign m_axis_tvalid   = vl_q[LAT-1];
  assign m_axis_tuser[0] = |sat;

endmodule
`default_nettype wire

[src/issc_chk.sv]
// Port-level checker for the isotropic stress/strain converter, with bind.
// Depends only on the top level's ports.
`default_nettype none
module issc_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [191:0] m_axis_tdata,
  input wire logic         pready
);

  // Output beat waits while stalled
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped under stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed under stall");

  // Input is taken whenever the output register can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // Config port never waits
  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind isotropic_stress_strain_convert issc_chk u_issc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);
`default_nettype wire
